[hdl/asd_pkg.sv]
`default_nettype none

package asd_pkg;

    // Field widths
    localparam int AXIS_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 32;
    localparam int RATE_W    = 16;

    // Magnitude path
    localparam int SQ_W      = 2 * AXIS_W;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int STEP_W    = $clog2(AXIS_W);

    // Averaging path, signed fixed point with FRAC_BITS fraction bits
    localparam int FRAC_BITS = 8;
    localparam int BAL_W     = CFG_W + 1;
    localparam int TGT_W     = BAL_W + FRAC_BITS;
    localparam int ACC_W     = 26;
    localparam int DIFF_W    = ACC_W + 1;
    localparam int WGT_W     = CFG_W;
    localparam int PROD_W    = DIFF_W + WGT_W;
    localparam int LEVEL_W   = ACC_W - FRAC_BITS - 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MINIVL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RATENUM = 3'd5;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_REST    = 16'd4132;
    localparam logic [CFG_W-1:0] RST_HIGH    = 16'd1000;
    localparam logic [CFG_W-1:0] RST_LOW     = 16'd700;
    localparam logic [CFG_W-1:0] RST_MINIVL  = 16'd50;
    localparam logic [CFG_W-1:0] RST_WEIGHT  = 16'd9830;
    localparam logic [CFG_W-1:0] RST_RATENUM = 16'd3000;

    typedef logic signed [AXIS_W-1:0] t_axis;
    typedef logic [TIME_W-1:0]        t_ticks;
    typedef logic [CFG_W-1:0]         t_cfg;
    typedef logic signed [ACC_W-1:0]  t_acc;

endpackage

`default_nettype wire

[hdl/asd_in_if.sv]
`default_nettype none

interface asd_in_if import asd_pkg::*; ();
    logic   valid;
    logic   ready;
    t_axis  accel_x;
    t_axis  accel_y;
    t_axis  accel_z;
    t_ticks now_ticks;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    output now_ticks, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    input now_ticks, output ready);
endinterface

`default_nettype wire

[hdl/asd_out_if.sv]
`default_nettype none

interface asd_out_if import asd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      stroke_seen;
    logic [COUNT_W-1:0]        stroke_total;
    logic [RATE_W-1:0]         strokes_per_minute;
    logic                      armed_now;
    logic signed [LEVEL_W-1:0] smoothed_level;

    modport source (output valid, output stroke_seen, output stroke_total,
                    output strokes_per_minute, output armed_now,
                    output smoothed_level, input ready);
    modport sink   (input valid, input stroke_seen, input stroke_total,
                    input strokes_per_minute, input armed_now,
                    input smoothed_level, output ready);
endinterface

`default_nettype wire

[hdl/asd_cfg_if.sv]
`default_nettype none

interface asd_cfg_if import asd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_cfg                 data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/accel_stroke_detector.sv]
// Stroke detector for a three-axis accelerometer. Each input beat carries one
// raw sample and the tick count; each produces exactly one result beat with the
// stroke flag, stroke count, last rate, armed flag and the integer part of the
// smoothed level. One sample is worked on at a time: the magnitude comes from a
// bit-serial sum of squares followed by a bit-serial square root, the averaging
// update runs in the shift-add multiplier, and a stroke after the first adds the
// serial divider and its hand-over. The next sample is taken the cycle after the
// result has moved to the output register; a result waiting in a full output
// register holds off the input. Registers may be written whenever no sample is
// in flight; there is no start-up clearing pass.
`default_nettype none

module accel_stroke_detector import asd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    asd_in_if.sink    i_in,
    asd_out_if.source o_out,
    asd_cfg_if.sink   i_cfg
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAG  = 3'd1;
    localparam logic [2:0] ST_FILT = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]         r_state, n_state;
    t_cfg               r_rest, r_high, r_low, r_minivl, r_weight, r_ratenum;
    logic               r_armed;
    logic               r_stroke_valid;
    logic               r_seen;
    t_ticks             r_last;
    t_ticks             r_now;
    logic [COUNT_W-1:0] r_count;
    logic [RATE_W-1:0]  r_rate;
    logic               r_out_valid;

    logic                      r_out_seen;
    logic [COUNT_W-1:0]        r_out_total;
    logic [RATE_W-1:0]         r_out_rate;
    logic                      r_out_armed;
    logic signed [LEVEL_W-1:0] r_out_level;

    logic                    in_accept;
    logic                    slot_free;
    logic                    mag_done;
    logic [ROOT_W-1:0]       mag_root;
    logic                    filt_start;
    logic                    filt_done;
    t_acc                    acc;
    logic signed [BAL_W-1:0] bal;
    logic signed [TGT_W-1:0] target;
    logic                    div_start;
    logic                    div_done;
    logic [RATE_W-1:0]       div_quot;
    t_ticks                  interval;
    t_acc                    hi_lvl, lo_lvl;
    logic                    hit;
    logic                    rearm;
    logic                    decide;

    assign in_accept   = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign slot_free   = !r_out_valid || o_out.ready;

    // Rest subtraction and threshold decision
    always_comb begin
        bal      = $signed({1'b0, mag_root}) - $signed({1'b0, r_rest});
        target   = {bal, {FRAC_BITS{1'b0}}};
        interval = r_now - r_last;
        hi_lvl   = $signed({{(ACC_W-CFG_W-FRAC_BITS){1'b0}}, r_high, {FRAC_BITS{1'b0}}});
        lo_lvl   = $signed({{(ACC_W-CFG_W-FRAC_BITS){1'b0}}, r_low, {FRAC_BITS{1'b0}}});
        hit      = r_armed && (acc > hi_lvl) && (interval > TIME_W'(r_minivl));
        rearm    = !r_armed && (acc < lo_lvl);
        decide   = (r_state == ST_FILT) && filt_done;
    end

    assign filt_start = (r_state == ST_MAG) && mag_done;
    assign div_start  = decide && hit && r_stroke_valid;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_accept) n_state = ST_MAG;
            ST_MAG:  if (mag_done) n_state = ST_FILT;
            ST_FILT: begin
                if (filt_done) n_state = div_start ? ST_DIV : ST_OUT;
            end
            ST_DIV:  if (div_done) n_state = ST_OUT;
            ST_OUT:  if (slot_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control and detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_rest         <= RST_REST;
            r_high         <= RST_HIGH;
            r_low          <= RST_LOW;
            r_minivl       <= RST_MINIVL;
            r_weight       <= RST_WEIGHT;
            r_ratenum      <= RST_RATENUM;
            r_armed        <= 1'b0;
            r_stroke_valid <= 1'b0;
            r_seen         <= 1'b0;
            r_last         <= '0;
            r_count        <= '0;
            r_rate         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            // Register writes, unknown indexes dropped
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_REST:    r_rest    <= i_cfg.data;
                    REG_HIGH:    r_high    <= i_cfg.data;
                    REG_LOW:     r_low     <= i_cfg.data;
                    REG_MINIVL:  r_minivl  <= i_cfg.data;
                    REG_WEIGHT:  r_weight  <= i_cfg.data;
                    REG_RATENUM: r_ratenum <= i_cfg.data;
                    default: ;
                endcase
            end

            if (in_accept) r_seen <= 1'b0;

            if (decide) begin
                if (hit) begin
                    r_count        <= r_count + 1'b1;
                    r_last         <= r_now;
                    r_stroke_valid <= 1'b1;
                    r_armed        <= 1'b0;
                    r_seen         <= 1'b1;
                end else if (rearm) begin
                    r_armed <= 1'b1;
                end
            end

            if ((r_state == ST_DIV) && div_done) r_rate <= div_quot;

            // Output slot: fill when free, drop once taken
            if ((r_state == ST_OUT) && slot_free) r_out_valid <= 1'b1;
            else if (o_out.ready)                  r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) r_now <= i_in.now_ticks;
        if ((r_state == ST_OUT) && slot_free) begin
            r_out_seen  <= r_seen;
            r_out_total <= r_count;
            r_out_rate  <= r_rate;
            r_out_armed <= r_armed;
            r_out_level <= acc[FRAC_BITS +: LEVEL_W];
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.stroke_seen        = r_out_seen;
    assign o_out.stroke_total       = r_out_total;
    assign o_out.strokes_per_minute = r_out_rate;
    assign o_out.armed_now          = r_out_armed;
    assign o_out.smoothed_level     = r_out_level;

    asd_magnitude u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_x     (i_in.accel_x),
        .i_y     (i_in.accel_y),
        .i_z     (i_in.accel_z),
        .o_done  (mag_done),
        .o_root  (mag_root)
    );

    asd_filter u_filt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (filt_start),
        .i_target (target),
        .i_weight (r_weight),
        .o_done   (filt_done),
        .o_acc    (acc)
    );

    asd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_ratenum),
        .i_den   (interval),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

endmodule

`default_nettype wire

[hdl/asd_magnitude.sv]
`default_nettype none

module asd_magnitude import asd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_axis             i_x,
    input  t_axis             i_y,
    input  t_axis             i_z,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(AXIS_W - 1);

    function automatic logic [AXIS_W-1:0] abs_axis(input t_axis v);
        logic [AXIS_W-1:0] neg;
        neg = AXIS_W'(-v);
        return v[AXIS_W-1] ? neg : AXIS_W'(v);
    endfunction

    logic              r_busy;
    logic              r_root_phase;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [AXIS_W-1:0] r_ax, r_ay, r_az;
    logic [AXIS_W-1:0] r_bx, r_by, r_bz;
    logic [SQ_W-1:0]   r_sum;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [SQ_W-1:0]   partial;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fits;

    // One multiplier bit of each square, one root bit per step
    always_comb begin
        partial = (r_bx[AXIS_W-1] ? SQ_W'(r_ax) : '0)
                + (r_by[AXIS_W-1] ? SQ_W'(r_ay) : '0)
                + (r_bz[AXIS_W-1] ? SQ_W'(r_az) : '0);
        rem_sh  = {r_rem[REM_W-3:0], r_sum[SQ_W-1 -: 2]};
        trial   = {r_root, 2'b01};
        fits    = (rem_sh >= trial);
    end

    // Sequence: square phase, then root phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_root_phase <= 1'b0;
            r_done       <= 1'b0;
            r_step       <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy       <= 1'b1;
                r_root_phase <= 1'b0;
                r_step       <= LAST_STEP;
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    if (!r_root_phase) begin
                        r_root_phase <= 1'b1;
                        r_step       <= LAST_STEP;
                    end else begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // Datapath shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ax   <= abs_axis(i_x);
            r_ay   <= abs_axis(i_y);
            r_az   <= abs_axis(i_z);
            r_bx   <= abs_axis(i_x);
            r_by   <= abs_axis(i_y);
            r_bz   <= abs_axis(i_z);
            r_sum  <= '0;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            if (!r_root_phase) begin
                r_sum <= {r_sum[SQ_W-2:0], 1'b0} + partial;
                r_bx  <= {r_bx[AXIS_W-2:0], 1'b0};
                r_by  <= {r_by[AXIS_W-2:0], 1'b0};
                r_bz  <= {r_bz[AXIS_W-2:0], 1'b0};
            end else begin
                r_sum  <= {r_sum[SQ_W-3:0], 2'b00};
                r_rem  <= fits ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[ROOT_W-2:0], fits};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

[hdl/asd_filter.sv]
`default_nettype none

module asd_filter import asd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [TGT_W-1:0] i_target,
    input  logic [WGT_W-1:0]        i_weight,
    output logic                    o_done,
    output t_acc                    o_acc
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WGT_W - 1);

    logic                     r_busy;
    logic                     r_update;
    logic                     r_done;
    logic [STEP_W-1:0]        r_step;
    t_acc                     r_acc;
    logic signed [DIFF_W-1:0] r_diff;
    logic [WGT_W-1:0]         r_wgt;
    logic signed [PROD_W-1:0] r_prod;

    logic signed [PROD_W-1:0] addend;
    logic signed [PROD_W-1:0] step_out;

    // Shift-add over the weight, most significant bit first
    always_comb begin
        addend   = r_wgt[WGT_W-1] ? PROD_W'(r_diff) : '0;
        step_out = (r_prod <<< 1) + addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_update <= 1'b0;
            r_done   <= 1'b0;
            r_step   <= '0;
            r_acc    <= '0;
        end else begin
            r_done   <= 1'b0;
            r_update <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= LAST_STEP;
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy   <= 1'b0;
                    r_update <= 1'b1;
                end
            end
            // Fold the scaled difference into the average
            if (r_update) begin
                r_acc  <= r_acc + ACC_W'(r_prod >>> WGT_W);
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_diff <= DIFF_W'(i_target) - DIFF_W'(r_acc);
            r_wgt  <= i_weight;
            r_prod <= '0;
        end else if (r_busy) begin
            r_prod <= step_out;
            r_wgt  <= {r_wgt[WGT_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

[hdl/asd_divider.sv]
`default_nettype none

module asd_divider import asd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RATE_W-1:0] i_num,
    input  t_ticks            i_den,
    output logic              o_done,
    output logic [RATE_W-1:0] o_quot
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RATE_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [RATE_W-1:0] r_num;
    t_ticks            r_den;
    logic [RATE_W-1:0] r_rem;
    logic [RATE_W-1:0] r_quot;

    logic [RATE_W:0]   rem_sh;
    logic              ge;
    logic [RATE_W:0]   diff;

    // One quotient bit per step, restoring
    always_comb begin
        rem_sh = {r_rem, r_num[RATE_W-1]};
        ge     = (TIME_W'(rem_sh) >= r_den);
        diff   = rem_sh - (RATE_W+1)'(r_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= LAST_STEP;
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[RATE_W-2:0], 1'b0};
            r_rem  <= ge ? diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
            r_quot <= {r_quot[RATE_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

[hdl/asd_checker.sv]
`default_nettype none

module asd_checker import asd_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_stroke_seen,
    input logic               i_armed_now,
    input logic [COUNT_W-1:0] i_stroke_total
);

    // Reset empties the output slot
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_stroke_total))
        else $error("stalled result beat changed");

    // A stroke always leaves the detector disarmed
    a_seen_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stroke_seen |-> !i_armed_now)
        else $error("stroke reported while armed");

    // One sample at a time: no beat right after an accepted one
    a_one_at_a_time: assert property (@(posedge i_clk)
        i_in_valid && i_in_ready && i_rst_n |=> !(i_in_valid && i_in_ready))
        else $error("input beats accepted back to back");

endmodule

bind accel_stroke_detector asd_checker u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_stroke_seen  (o_out.stroke_seen),
    .i_armed_now    (o_out.armed_now),
    .i_stroke_total (o_out.stroke_total)
);

`default_nettype wire

[tb/accel_stroke_detector_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module accel_stroke_detector_chk import asd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    asd_in_if    i_in,
    asd_out_if   i_out,
    asd_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int MAX_REPORTED = 10;

    typedef struct packed {
        logic               seen;
        logic [COUNT_W-1:0] total;
        logic [RATE_W-1:0]  rate;
        logic               armed;
        logic [LEVEL_W-1:0] level;
    } t_stroke_report;

    // Shadow registers
    t_cfg   rest_lvl;
    t_cfg   hi_thr;
    t_cfg   lo_thr;
    t_cfg   min_ivl;
    t_cfg   weight;
    t_cfg   rate_num;

    // Detector state as the block should hold it
    longint             level_acc;
    logic               armed_q;
    t_ticks             last_stroke_tick;
    logic [COUNT_W-1:0] stroke_cnt;
    logic [RATE_W-1:0]  rate_q;
    logic               had_stroke;

    t_stroke_report expected_reports[$];
    t_stroke_report got_report;
    t_stroke_report want_report;
    int             report_idx;

    // Floor square root, one result bit per trial from the top down
    function automatic longint floor_sqrt(longint sum_sq);
        longint root;
        longint trial;
        root = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= sum_sq) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Advance the detector by one sample and return the report it gives
    function automatic t_stroke_report advance_detector(t_axis ax, t_axis ay, t_axis az,
                                                        t_ticks now);
        longint         sum_sq;
        longint         bal;
        longint         hi_fixed;
        longint         lo_fixed;
        t_ticks         gap;
        t_stroke_report rep;
        sum_sq = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
               + longint'(az) * longint'(az);
        bal = floor_sqrt(sum_sq) - longint'(rest_lvl);
        // Arithmetic shift of a signed product floors towards minus infinity
        level_acc = level_acc
                  + ((longint'(weight) * ((bal <<< FRAC_BITS) - level_acc)) >>> 16);
        rep.seen = 1'b0;
        if (armed_q) begin
            gap      = now - last_stroke_tick;
            hi_fixed = longint'(hi_thr) <<< FRAC_BITS;
            if (level_acc > hi_fixed && gap > t_ticks'(min_ivl)) begin
                if (had_stroke) begin
                    rate_q = RATE_W'(t_ticks'(rate_num) / gap);
                end
                stroke_cnt       = stroke_cnt + 1'b1;
                last_stroke_tick = now;
                had_stroke       = 1'b1;
                armed_q          = 1'b0;
                rep.seen         = 1'b1;
            end
        end else begin
            lo_fixed = longint'(lo_thr) <<< FRAC_BITS;
            if (level_acc < lo_fixed) begin
                armed_q = 1'b1;
            end
        end
        rep.total = stroke_cnt;
        rep.rate  = rate_q;
        rep.armed = armed_q;
        rep.level = LEVEL_W'(level_acc >>> FRAC_BITS);
        return rep;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rest_lvl         = RST_REST;
            hi_thr           = RST_HIGH;
            lo_thr           = RST_LOW;
            min_ivl          = RST_MINIVL;
            weight           = RST_WEIGHT;
            rate_num         = RST_RATENUM;
            level_acc        = 0;
            armed_q          = 1'b0;
            last_stroke_tick = '0;
            stroke_cnt       = '0;
            rate_q           = '0;
            had_stroke       = 1'b0;
            report_idx       = 0;
            o_fail_count     = 0;
            expected_reports.delete();
        end else begin
            // Compare each result beat with the oldest expectation
            if (i_out.valid && i_out.ready) begin
                got_report.seen  = i_out.stroke_seen;
                got_report.total = i_out.stroke_total;
                got_report.rate  = i_out.strokes_per_minute;
                got_report.armed = i_out.armed_now;
                got_report.level = i_out.smoothed_level;
                if (expected_reports.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTED) begin
                        $display("%0t: result beat %0d arrived with nothing expected",
                                 $time, report_idx);
                    end
                end else begin
                    want_report = expected_reports.pop_front();
                    if (got_report !== want_report) begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_REPORTED) begin
                            $display("%0t: result beat %0d differs (expected/actual):",
                                     $time, report_idx);
                            $display("  seen %0b/%0b total %0d/%0d rate %0d/%0d",
                                     want_report.seen, got_report.seen,
                                     want_report.total, got_report.total,
                                     want_report.rate, got_report.rate);
                            $display("  armed %0b/%0b level %0d/%0d",
                                     want_report.armed, got_report.armed,
                                     $signed(want_report.level), $signed(got_report.level));
                        end
                    end
                end
                report_idx++;
            end

            // Follow register writes; unused indexes are dropped
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_REST: begin
                        rest_lvl = i_cfg.data;
                    end
                    REG_HIGH: begin
                        hi_thr = i_cfg.data;
                    end
                    REG_LOW: begin
                        lo_thr = i_cfg.data;
                    end
                    REG_MINIVL: begin
                        min_ivl = i_cfg.data;
                    end
                    REG_WEIGHT: begin
                        weight = i_cfg.data;
                    end
                    REG_RATENUM: begin
                        rate_num = i_cfg.data;
                    end
                    default: begin
                    end
                endcase
            end

            // Predict the report for each accepted sample
            if (i_in.valid && i_in.ready) begin
                expected_reports.push_back(advance_detector(i_in.accel_x, i_in.accel_y,
                                                            i_in.accel_z, i_in.now_ticks));
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

`default_nettype wire

[tb/accel_stroke_detector_tb.sv]
`timescale 1ns / 1ps
`default_nettype none

module accel_stroke_detector_tb;
    import asd_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 500000;
    localparam int IDLE_PCT    = 24;
    localparam int TAIL_CYCLES = 100;
    localparam int MAG_MAX     = 56755;

    localparam t_axis AX_MIN = t_axis'(16'h8000);
    localparam t_axis AX_MAX = t_axis'(16'h7FFF);
    localparam t_axis AX_NIL = t_axis'(16'h0000);

    // Indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   calm    = 1'b0;
    int     cycle_count = 0;
    int     fail_count;
    int     pending;
    int     samples_sent = 0;
    int     tick_step_max = 8;
    t_ticks tick_now = '0;

    // Settings the gestures are shaped around
    t_cfg cur_rest = RST_REST;
    t_cfg cur_high = RST_HIGH;
    t_cfg cur_low  = RST_LOW;

    asd_in_if  in_ch ();
    asd_out_if out_ch ();
    asd_cfg_if cfg_ch ();

    accel_stroke_detector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    accel_stroke_detector_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Stall the result side at random unless in a calm stretch
    always @(negedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
    end

    // Abandon a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one sample after random idle cycles; return at the falling edge after the beat
    task automatic send_sample(input t_axis ax, input t_axis ay, input t_axis az,
                               input t_ticks now);
        while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
            in_ch.valid     <= 1'b0;
            in_ch.accel_x   <= t_axis'($urandom);
            in_ch.accel_y   <= t_axis'($urandom);
            in_ch.accel_z   <= t_axis'($urandom);
            in_ch.now_ticks <= t_ticks'($urandom);
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.accel_x   <= ax;
        in_ch.accel_y   <= ay;
        in_ch.accel_z   <= az;
        in_ch.now_ticks <= now;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        samples_sent++;
        @(negedge i_clk);
    endtask

    // Hold valid high across back-to-back writes; the caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_cfg value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Write every register, poke the unused indexes, then release the channel
    task automatic program_regs(input t_cfg rest, input t_cfg high, input t_cfg low,
                                input t_cfg minivl, input t_cfg wgt, input t_cfg num);
        write_reg(REG_REST, rest);
        write_reg(REG_HIGH, high);
        write_reg(REG_LOW, low);
        write_reg(REG_MINIVL, minivl);
        write_reg(REG_WEIGHT, wgt);
        write_reg(REG_RATENUM, num);
        write_reg(REG_SPARE_A, t_cfg'($urandom));
        write_reg(REG_SPARE_B, t_cfg'($urandom));
        cfg_ch.valid <= 1'b0;
        cur_rest      = rest;
        cur_high      = high;
        cur_low       = low;
        tick_step_max = int'(minivl) / 8 + 3;
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every result to come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    // Send a sample of roughly the given magnitude with a random direction
    task automatic send_level(input int mag);
        int comp[3];
        int lane;
        int tmp;
        if (mag > MAG_MAX) begin
            mag = MAG_MAX;
        end
        if (mag < 0) begin
            mag = 0;
        end
        if (mag <= 32767) begin
            comp[0] = mag;
            comp[1] = $urandom_range(255, 0);
            comp[2] = $urandom_range(255, 0);
        end else begin
            comp[0] = mag * 577 / 1000;
            comp[1] = comp[0];
            comp[2] = comp[0];
        end
        lane       = $urandom_range(2, 0);
        tmp        = comp[0];
        comp[0]    = comp[lane];
        comp[lane] = tmp;
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(1, 0) == 1) begin
                comp[i] = -comp[i];
            end
        end
        // Advance time, now and then with a large jump
        if ($urandom_range(31, 0) == 0) begin
            tick_now = tick_now + t_ticks'($urandom);
        end else begin
            tick_now = tick_now + t_ticks'($urandom_range(tick_step_max, 1));
        end
        send_sample(t_axis'(comp[0]), t_axis'(comp[1]), t_axis'(comp[2]), tick_now);
    endtask

    // One swing: a burst above the stroke level, then a fall below re-arm level
    task automatic send_gesture();
        int hi_level;
        int lo_level;
        int margin;
        margin   = $urandom_range(3000, 1);
        hi_level = int'(cur_rest) + int'(cur_high) + margin;
        margin   = $urandom_range(3000, 1);
        lo_level = int'(cur_rest) + int'(cur_low) - margin;
        repeat ($urandom_range(6, 1)) begin
            send_level(hi_level);
        end
        repeat ($urandom_range(6, 1)) begin
            send_level(lo_level);
        end
    endtask

    // Mostly well-formed swings, the rest raw noise
    task automatic run_phase(input int n_items);
        int goal;
        goal = samples_sent + n_items;
        if ($urandom_range(3, 0) == 0) begin
            tick_now = 32'hFFFF_FF00 + t_ticks'($urandom_range(200, 0));
        end
        while (samples_sent < goal) begin
            if ($urandom_range(99, 0) < 80) begin
                send_gesture();
            end else if ($urandom_range(1, 0) == 1) begin
                send_sample(t_axis'($urandom), t_axis'($urandom), t_axis'($urandom),
                            t_ticks'($urandom));
            end else begin
                tick_now = tick_now + t_ticks'($urandom_range(tick_step_max, 1));
                send_sample(t_axis'($urandom), t_axis'($urandom), t_axis'($urandom),
                            tick_now);
            end
        end
        drain();
    endtask

    task automatic random_settings();
        t_cfg high;
        high = t_cfg'($urandom_range(20000, 1));
        program_regs(t_cfg'($urandom_range(12000, 0)), high,
                     t_cfg'($urandom_range(int'(high), 0)),
                     t_cfg'($urandom_range(400, 0)),
                     t_cfg'($urandom_range(65535, 6000)),
                     t_cfg'($urandom_range(65535, 1)));
    endtask

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.accel_x   = '0;
        in_ch.accel_y   = '0;
        in_ch.accel_z   = '0;
        in_ch.now_ticks = '0;
        out_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a near-unity weight lets each sample land almost on its level
        program_regs(RST_REST, RST_HIGH, RST_LOW, RST_MINIVL, 16'hFFFF, RST_RATENUM);
        send_sample(AX_NIL, AX_NIL, AX_NIL, 32'd10);                 // arm
        send_sample(AX_MIN, AX_MIN, AX_MIN, 32'd20);                 // too soon after tick zero
        send_sample(AX_MAX, AX_MAX, AX_MAX, 32'hFFFF_FF00);          // first stroke, no rate
        send_sample(AX_MAX, AX_MIN, AX_NIL, 32'h0000_1234);          // high while disarmed
        send_sample(AX_NIL, AX_NIL, AX_NIL, 32'd7);                  // re-arm
        send_sample(AX_MIN, AX_NIL, AX_MAX, 32'd0);                  // stroke at tick zero, wraps
        send_sample(AX_NIL, AX_NIL, AX_NIL, 32'd1);                  // re-arm
        send_sample(AX_NIL, AX_MIN, AX_NIL, 32'd5);                  // interval too short
        send_sample(t_axis'(1), t_axis'(-1), t_axis'(1), 32'd300);   // low, stay armed
        send_sample(AX_MAX, AX_MAX, AX_MAX, 32'd300);                // stroke with rate
        send_sample(t_axis'(4132), AX_NIL, AX_NIL, 32'd301);         // level exactly at rest
        send_sample(t_axis'(-1), t_axis'(-1), t_axis'(-1), 32'hFFFF_FFFF);
        drain();
        // Zero weight holds the average
        program_regs(RST_REST, RST_HIGH, RST_LOW, RST_MINIVL, 16'h0000, RST_RATENUM);
        send_sample(AX_MAX, AX_MAX, AX_MAX, 32'd600);
        send_sample(AX_MIN, AX_MAX, AX_MIN, 32'd700);
        drain();
        // Zero rate numerator gives a zero rate; no minimum interval
        program_regs(RST_REST, RST_HIGH, RST_LOW, 16'h0000, 16'hFFFF, 16'h0000);
        send_sample(AX_MAX, AX_MIN, AX_MAX, 32'd1000);
        send_sample(AX_NIL, AX_NIL, AX_NIL, 32'd1001);
        send_sample(AX_MAX, AX_NIL, AX_NIL, 32'd1002);
        drain();

        // Random phases over several settings, the extremes among them
        program_regs(RST_REST, RST_HIGH, RST_LOW, RST_MINIVL, RST_WEIGHT, RST_RATENUM);
        run_phase(150);
        program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001);
        run_phase(40);
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(40);
        random_settings();
        calm = 1'b1;
        run_phase(100);
        calm = 1'b0;
        repeat (3) begin
            random_settings();
            run_phase(100);
        end

        wait (pending == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
